// File: hw/rtl/ezr_pkg.sv
// ----------------------------------------------------------------------------
// ezr_pkg
// Shared types, constants and helper functions for the z-x-y rotation matrix.
// ----------------------------------------------------------------------------
package ezr_pkg;

  localparam logic [63:0] PER_DEGREE = 64'h00B6_0B60_B60B_60B6;
  localparam logic [63:0] PER_RADIAN = 64'h28BE_60DB_9391_054A;
  localparam logic signed [33:0] CORDIC_START = 34'sd652032874;
  localparam logic signed [21:0] ONE_Q16 = 22'sd65536;

  typedef struct packed {
    logic               valid;
    logic               flip;
    logic signed [33:0] x;
    logic signed [33:0] y;
    logic signed [33:0] z;
  } cordic_t;

  function automatic logic [31:0] atan_turn(input logic [4:0] idx);
    logic [31:0] r;
    unique case (idx)
      5'd0:  r = 32'h20000000;
      5'd1:  r = 32'h12E4051D;
      5'd2:  r = 32'h09FB385B;
      5'd3:  r = 32'h051111D4;
      5'd4:  r = 32'h028B0D43;
      5'd5:  r = 32'h0145D7E1;
      5'd6:  r = 32'h00A2F61E;
      5'd7:  r = 32'h00517C55;
      5'd8:  r = 32'h0028BE53;
      5'd9:  r = 32'h00145F2E;
      5'd10: r = 32'h000A2F98;
      5'd11: r = 32'h000517CC;
      5'd12: r = 32'h00028BE6;
      5'd13: r = 32'h000145F3;
      5'd14: r = 32'h0000A2F9;
      5'd15: r = 32'h0000517C;
      5'd16: r = 32'h000028BE;
      5'd17: r = 32'h0000145F;
      5'd18: r = 32'h00000A2F;
      5'd19: r = 32'h00000517;
      5'd20: r = 32'h0000028B;
      5'd21: r = 32'h00000145;
      5'd22: r = 32'h000000A2;
      5'd23: r = 32'h00000051;
      default: r = 32'h0;
    endcase
    return r;
  endfunction

  function automatic logic signed [17:0] clamp_one(input logic signed [21:0] v);
    logic signed [17:0] r;
    if (v > ONE_Q16) begin
      r = 18'sd65536;
    end else if (v < -ONE_Q16) begin
      r = -18'sd65536;
    end else begin
      r = v[17:0];
    end
    return r;
  endfunction

  function automatic logic signed [17:0] finish(input logic signed [53:0] v);
    logic signed [53:0] t;
    t = (v + 54'sd2147483648) >>> 32;
    return clamp_one(t[21:0]);
  endfunction

endpackage

// File: hw/rtl/ezr_ifs.sv
// ----------------------------------------------------------------------------
// ezr interfaces
// Valid/ready channels for configuration, angle triples and matrix beats.
// ----------------------------------------------------------------------------
interface ezr_cfg_if;
  logic valid;
  logic ready;
  logic data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface ezr_angle_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] angle_about_z;
  logic signed [31:0] angle_about_x;
  logic signed [31:0] angle_about_y;
  modport source (output valid, output angle_about_z, output angle_about_x,
                  output angle_about_y, input ready);
  modport sink (input valid, input angle_about_z, input angle_about_x,
                input angle_about_y, output ready);
endinterface

interface ezr_matrix_if;
  logic               valid;
  logic               ready;
  logic signed [17:0] entry_xx;
  logic signed [17:0] entry_xy;
  logic signed [17:0] entry_xz;
  logic signed [17:0] entry_yx;
  logic signed [17:0] entry_yy;
  logic signed [17:0] entry_yz;
  logic signed [17:0] entry_zx;
  logic signed [17:0] entry_zy;
  logic signed [17:0] entry_zz;
  modport source (output valid, output entry_xx, output entry_xy, output entry_xz,
                  output entry_yx, output entry_yy, output entry_yz,
                  output entry_zx, output entry_zy, output entry_zz, input ready);
  modport sink (input valid, input entry_xx, input entry_xy, input entry_xz,
                input entry_yx, input entry_yy, input entry_yz,
                input entry_zx, input entry_zy, input entry_zz, output ready);
endinterface

// File: hw/rtl/ezr_cordic_cell.sv
// ----------------------------------------------------------------------------
// ezr_cordic_cell
// One rotation-mode CORDIC iteration, registered, passed to the next cell.
// ----------------------------------------------------------------------------
module ezr_cordic_cell #(
  parameter int STAGE_IDX = 0
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            en,
  input  ezr_pkg::cordic_t din,
  output ezr_pkg::cordic_t dout
);
  import ezr_pkg::*;

  logic signed [33:0] dx;
  logic signed [33:0] dy;
  logic signed [33:0] at;
  cordic_t            dout_next;

  always_comb begin
    dx = din.y >>> STAGE_IDX;
    dy = din.x >>> STAGE_IDX;
    at = $signed({2'b00, atan_turn(5'(STAGE_IDX))});
    dout_next = din;
    if (!din.z[33]) begin
      dout_next.x = din.x - dx;
      dout_next.y = din.y + dy;
      dout_next.z = din.z - at;
    end else begin
      dout_next.x = din.x + dx;
      dout_next.y = din.y - dy;
      dout_next.z = din.z + at;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      dout.valid <= 1'b0;
    end else if (en) begin
      dout <= dout_next;
    end
  end

endmodule

// File: hw/rtl/ezr_sincos.sv
// ----------------------------------------------------------------------------
// ezr_sincos
// Angle to phase, quadrant fold, chain of CORDIC cells, rounding to Q1.16.
// ----------------------------------------------------------------------------
module ezr_sincos #(
  parameter int TRIG_STAGES     = 16,
  parameter int ANGLE_FRAC_BITS = 16
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               en,
  input  logic               in_valid,
  input  logic               degrees,
  input  logic signed [31:0] angle,
  output logic               out_valid,
  output logic signed [17:0] sin_q,
  output logic signed [17:0] cos_q
);
  import ezr_pkg::*;

  logic        v1;
  logic        neg1;
  logic [63:0] p0;
  logic [63:0] p1;
  logic        v2;
  logic [31:0] phase;
  cordic_t     chain [TRIG_STAGES+1];

  logic        neg_in;
  logic [31:0] mag;
  logic [63:0] k_sel;
  logic [63:0] mid;
  logic [31:0] ph;
  logic [31:0] fold;
  cordic_t     start;
  logic signed [33:0] xf;
  logic signed [33:0] yf;
  logic signed [33:0] xr;
  logic signed [33:0] yr;

  always_comb begin
    neg_in = angle[31];
    mag    = neg_in ? (~angle + 32'd1) : angle;
    k_sel  = degrees ? PER_DEGREE : PER_RADIAN;
    mid    = {32'd0, p0[63:32]} + p1 + (64'd1 << (ANGLE_FRAC_BITS - 1));
    ph     = mid[ANGLE_FRAC_BITS +: 32];
    if (neg1) begin
      ph = ~ph + 32'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
    end else if (en) begin
      v1 <= in_valid;
      v2 <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      neg1  <= neg_in;
      p0    <= 64'(mag) * 64'(k_sel[31:0]);
      p1    <= 64'(mag) * 64'(k_sel[63:32]);
      phase <= ph;
    end
  end

  // fold the left half-plane by half a turn
  always_comb begin
    fold        = phase + 32'h4000_0000;
    start.valid = v2;
    start.flip  = fold[31];
    start.x     = CORDIC_START;
    start.y     = '0;
    start.z     = 34'($signed({fold[31] ^ phase[31], phase[30:0]}));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      chain[0].valid <= 1'b0;
    end else if (en) begin
      chain[0] <= start;
    end
  end

  for (genvar g = 0; g < TRIG_STAGES; g++) begin : g_cell
    ezr_cordic_cell #(.STAGE_IDX(g)) u_cell (
      .clk  (clk),
      .rst  (rst),
      .en   (en),
      .din  (chain[g]),
      .dout (chain[g+1])
    );
  end

  always_comb begin
    xf = chain[TRIG_STAGES].flip ? -chain[TRIG_STAGES].x : chain[TRIG_STAGES].x;
    yf = chain[TRIG_STAGES].flip ? -chain[TRIG_STAGES].y : chain[TRIG_STAGES].y;
    xr = (xf + 34'sd8192) >>> 14;
    yr = (yf + 34'sd8192) >>> 14;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= chain[TRIG_STAGES].valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      cos_q <= clamp_one(xr[21:0]);
      sin_q <= clamp_one(yr[21:0]);
    end
  end

endmodule

// File: hw/rtl/euler_zxy_rotation_matrix.sv
// ----------------------------------------------------------------------------
// euler_zxy_rotation_matrix
// Z-X-Y Euler angles to a saturated Q1.16 3x3 rotation matrix.
// ----------------------------------------------------------------------------
// Takes one angle triple per clock and returns one matrix beat per triple,
// in order; the whole datapath is one pipeline that stalls only when the
// output register is full and not taken. The pipeline is the CORDIC cell
// chain (one cell per iteration) plus two phase stages, one fold stage,
// one rounding stage and three matrix stages.
// Write cfg.data = 1 for degrees, 0 for radians (reset: degrees) while idle.
module euler_zxy_rotation_matrix #(
  parameter int TRIG_STAGES     = 16,
  parameter int ANGLE_FRAC_BITS = 16
) (
  input  logic                clk,
  input  logic                rst,
  ezr_cfg_if.sink             cfg,
  ezr_angle_if.sink           angles,
  ezr_matrix_if.source        matrix
);
  import ezr_pkg::*;

  logic               degrees;
  logic               en;
  logic [2:0]         sc_valid;
  logic signed [17:0] s [3];
  logic signed [17:0] c [3];
  logic signed [31:0] ang [3];

  logic               va;
  logic signed [35:0] cy_cz, sx_sy, cx_sz, sy_cz, sx_cy, cy_sz, cx_cz, sy_sz, cx_sy, cx_cy;
  logic signed [17:0] sz_a, cz_a, sx_a;
  logic               vb;
  logic signed [53:0] v [9];

  assign cfg.ready    = 1'b1;
  assign en           = !matrix.valid || matrix.ready;
  assign angles.ready = en;
  assign ang[0]       = angles.angle_about_z;
  assign ang[1]       = angles.angle_about_x;
  assign ang[2]       = angles.angle_about_y;

  always_ff @(posedge clk) begin
    if (rst) begin
      degrees <= 1'b1;
    end else if (cfg.valid && cfg.ready) begin
      degrees <= cfg.data;
    end
  end

  // lane 0: z, lane 1: x, lane 2: y
  for (genvar g = 0; g < 3; g++) begin : g_lane
    ezr_sincos #(
      .TRIG_STAGES     (TRIG_STAGES),
      .ANGLE_FRAC_BITS (ANGLE_FRAC_BITS)
    ) u_sincos (
      .clk       (clk),
      .rst       (rst),
      .en        (en),
      .in_valid  (angles.valid && angles.ready),
      .degrees   (degrees),
      .angle     (ang[g]),
      .out_valid (sc_valid[g]),
      .sin_q     (s[g]),
      .cos_q     (c[g])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      va           <= 1'b0;
      vb           <= 1'b0;
      matrix.valid <= 1'b0;
    end else if (en) begin
      va           <= sc_valid[0];
      vb           <= va;
      matrix.valid <= vb;
    end
  end

  // pair products
  always_ff @(posedge clk) begin
    if (en) begin
      cy_cz <= c[2] * c[0];
      sx_sy <= s[1] * s[2];
      cx_sz <= c[1] * s[0];
      sy_cz <= s[2] * c[0];
      sx_cy <= s[1] * c[2];
      cy_sz <= c[2] * s[0];
      cx_cz <= c[1] * c[0];
      sy_sz <= s[2] * s[0];
      cx_sy <= c[1] * s[2];
      cx_cy <= c[1] * c[2];
      sz_a  <= s[0];
      cz_a  <= c[0];
      sx_a  <= s[1];
    end
  end

  // triple products and sums at 48 fraction bits
  always_ff @(posedge clk) begin
    if (en) begin
      v[0] <= (54'(cy_cz) <<< 16) - 54'(sx_sy) * 54'(sz_a);
      v[1] <= -(54'(cx_sz) <<< 16);
      v[2] <= 54'(sx_cy) * 54'(sz_a) + (54'(sy_cz) <<< 16);
      v[3] <= (54'(cy_sz) <<< 16) + 54'(sx_sy) * 54'(cz_a);
      v[4] <= 54'(cx_cz) <<< 16;
      v[5] <= (54'(sy_sz) <<< 16) - 54'(sx_cy) * 54'(cz_a);
      v[6] <= -(54'(cx_sy) <<< 16);
      v[7] <= 54'(sx_a) <<< 32;
      v[8] <= 54'(cx_cy) <<< 16;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      matrix.entry_xx <= finish(v[0]);
      matrix.entry_xy <= finish(v[1]);
      matrix.entry_xz <= finish(v[2]);
      matrix.entry_yx <= finish(v[3]);
      matrix.entry_yy <= finish(v[4]);
      matrix.entry_yz <= finish(v[5]);
      matrix.entry_zx <= finish(v[6]);
      matrix.entry_zy <= finish(v[7]);
      matrix.entry_zz <= finish(v[8]);
    end
  end

`ifndef SYNTHESIS
  a_cfg_write: assert property (@(posedge clk) disable iff (rst)
    cfg.valid && cfg.ready |=> degrees == $past(cfg.data))
    else $error("config write lost");

  a_lanes_aligned: assert property (@(posedge clk) disable iff (rst)
    sc_valid[0] == sc_valid[1] && sc_valid[1] == sc_valid[2])
    else $error("trig lanes out of step");

  a_entry_range: assert property (@(posedge clk) disable iff (rst)
    matrix.valid |-> matrix.entry_xx <= 18'sd65536 && matrix.entry_xx >= -18'sd65536
      && matrix.entry_yz <= 18'sd65536 && matrix.entry_yz >= -18'sd65536)
    else $error("entry outside unit range");
`endif

endmodule
